// ----- rtl/sil_pkg.sv -----
package sil_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W      = 32;
  localparam int KIND_W     = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  value;
    logic              last;
  } res_item_t;

endpackage

// ----- rtl/sil_ram.sv -----
module sil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/sil_outreg.sv -----
module sil_outreg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  sil_pkg::res_item_t          item,
  output logic                        free,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sil_pkg::VAL_W-1:0]   out_tdata,  // value_res
  output logic [sil_pkg::KIND_W-1:0]  out_tuser,  // result_kind
  output logic                        out_tlast
);
  import sil_pkg::*;

  logic      valid_r;
  res_item_t item_r;

  assign free = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
    if (push) begin
      item_r <= item;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = item_r.value;
  assign out_tuser  = item_r.kind;
  assign out_tlast  = item_r.last;

endmodule

// ----- rtl/sorted_insertion_list.sv -----
// Insert: a full list drops the value, an empty one stores it in slot 0; otherwise the list is
// walked down from its last entry, each entry read and compared and each larger one moved up
// one slot, then the value is written into the freed slot or slot 0. List: an empty list gives
// one EMPTY result, else the entries go out from slot 0 upward, each read and then pushed. One
// item at a time: in_tready rises as the final result is registered; output stalls delay it.
// Reset (rst_n low, synchronous) empties the list and drops any pending result; slots stay.
module sorted_insertion_list (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [sil_pkg::VAL_W-1:0]   in_tdata,   // value
  input  logic                        in_tuser,   // operation
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [sil_pkg::VAL_W-1:0]   out_tdata,  // value_res
  output logic [sil_pkg::KIND_W-1:0]  out_tuser,  // result_kind
  output logic                        out_tlast
);
  import sil_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INS_RD, ST_INS_CMP, ST_INS_PUT, ST_LST_RD, ST_LST_WAIT, ST_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [VAL_W-1:0]  ram_rdata;

  logic              push;
  res_item_t         push_item;
  logic              out_free;
  logic              greater;
  logic              last_entry;

  sil_ram #(.WIDTH(VAL_W), .DEPTH(LIST_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  sil_outreg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .item       (push_item),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign in_tready  = (state_r == ST_IDLE);
  // The signed compare unit: stored entry against the value being inserted.
  assign greater    = $signed(ram_rdata) > $signed(val_r);
  assign last_entry = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    val_nxt   = val_r;
    kind_nxt  = kind_r;
    ram_we    = 1'b0;
    ram_waddr = idx_r + IDX_W'(1);
    ram_wdata = ram_rdata;
    push      = 1'b0;
    push_item = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          val_nxt = in_tdata;
          if (in_tuser == OP_INSERT) begin
            if (count_r == CNT_W'(LIST_DEPTH)) begin
              kind_nxt  = KIND_DROPPED;
              state_nxt = ST_RESP;
            end else if (count_r == '0) begin
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = in_tdata;
              count_nxt = count_r + CNT_W'(1);
              kind_nxt  = KIND_INSERTED;
              state_nxt = ST_RESP;
            end else begin
              idx_nxt   = IDX_W'(count_r - CNT_W'(1));
              state_nxt = ST_INS_RD;
            end
          end else begin
            if (count_r == '0) begin
              kind_nxt  = KIND_EMPTY;
              state_nxt = ST_RESP;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_LST_RD;
            end
          end
        end
      end
      ST_INS_RD: begin
        state_nxt = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (greater) begin
          // Move the larger entry up one slot and keep walking down, or put the value in slot 0 after it.
          if (idx_r == '0) begin
            state_nxt = ST_INS_PUT;
          end else begin
            idx_nxt   = idx_r - IDX_W'(1);
            state_nxt = ST_INS_RD;
          end
        end else begin
          ram_wdata = val_r;
          count_nxt = count_r + CNT_W'(1);
          kind_nxt  = KIND_INSERTED;
          state_nxt = ST_RESP;
        end
      end
      ST_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        count_nxt = count_r + CNT_W'(1);
        kind_nxt  = KIND_INSERTED;
        state_nxt = ST_RESP;
      end
      ST_LST_RD: begin
        state_nxt = ST_LST_WAIT;
      end
      ST_LST_WAIT: begin
        // The read address is held here, so the read data stays valid while stalled.
        if (out_free) begin
          push            = 1'b1;
          push_item.kind  = KIND_ENTRY;
          push_item.value = ram_rdata;
          push_item.last  = last_entry;
          if (last_entry) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = ST_LST_RD;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          push            = 1'b1;
          push_item.kind  = kind_r;
          push_item.value = '0;
          push_item.last  = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    kind_r <= kind_nxt;
  end

endmodule

// ----- rtl/sil_checker.sv -----
module sil_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [sil_pkg::VAL_W-1:0]   out_tdata,
  input logic [sil_pkg::KIND_W-1:0]  out_tuser,
  input logic                        out_tlast
);
  import sil_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed or dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before the previous item finished");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_ENTRY |-> out_tlast && out_tdata == '0)
    else $error("non-entry result must be last and carry zero");

  // While a list is still being walked the input stays closed.
  a_entry_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ENTRY && !out_tlast |-> !in_tready)
    else $error("input open while a list is still being emitted");

endmodule

bind sorted_insertion_list sil_checker u_sil_checker (.*);
